/* src/pps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg: shared constants for the preemptive priority scheduler
// Field widths, parameter defaults and operation codes.
// ----------------------------------------------------------------------------
package pps_pkg;

    // Parameter defaults
    localparam int SLOTS_DEF     = 8;
    localparam int TIME_BITS_DEF = 16;

    // Fixed field widths of the item and result words
    localparam int SLOT_FIELD_W  = 3;
    localparam int TIME_FIELD_W  = 16;
    localparam int LEN_W         = 16;
    localparam int PRIO_W        = 8;
    localparam int EXEC_W        = 16;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

/* src/preemptive_priority_scheduler_top.sv */
`timescale 1ns / 1ps
// Load word: accepted while idle; the slot table entry is written at once.
// Tick word: input stays stalled through the scan and the update; the update
// waits for a free result register, registers the result word and returns to
// idle. The scan uses the table's single read port, one slot a cycle.
// Reset (synchronous, active low) marks every slot not runnable, clears time
// and the running task; no clearing pass is needed.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top: task slot table with priority pick
// Holds task slots in a synchronous memory, scans them on every tick for the
// highest-priority ready task, credits it one tick and reports the outcome.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top #(
    parameter int SLOTS     = pps_pkg::SLOTS_DEF,
    parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_operation,
    input  logic [pps_pkg::SLOT_FIELD_W-1:0]  i_slot,
    input  logic [pps_pkg::TIME_FIELD_W-1:0]  i_arrive_at,
    input  logic [pps_pkg::LEN_W-1:0]         i_run_length,
    input  logic [pps_pkg::PRIO_W-1:0]        i_urgency,
    // Output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [pps_pkg::SLOT_FIELD_W-1:0]  o_running_slot,
    output logic                              o_idle,
    output logic                              o_finished,
    output logic [pps_pkg::EXEC_W-1:0]        o_progress,
    output logic [pps_pkg::TIME_FIELD_W-1:0]  o_now
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EXT_W  = SLOT_W + pps_pkg::SLOT_FIELD_W;
    localparam int CNT_W  = SLOT_W + 1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    typedef struct packed {
        logic [TIME_BITS-1:0]         arrive;
        logic [pps_pkg::LEN_W-1:0]    len;
        logic [pps_pkg::PRIO_W-1:0]   prio;
        logic [pps_pkg::EXEC_W-1:0]   exec;
        logic                         done;
    } t_entry;

    // Slot table memory and per-entry written marks
    t_entry                    mem [SLOTS];
    logic [SLOTS-1:0]          r_written;
    t_entry                    r_rd_data;
    logic                      r_rd_written;

    logic [1:0]                r_state;
    logic [CNT_W-1:0]          r_issue;
    logic                      r_chk_valid;
    logic [SLOT_W-1:0]         r_chk_idx;

    // Best candidate of the current scan
    logic                      r_found;
    logic [SLOT_W-1:0]         r_best_idx;
    t_entry                    r_best;

    // Scheduler state
    logic [TIME_BITS-1:0]      r_time;
    logic [pps_pkg::PRIO_W-1:0] r_cur_urg;
    logic [SLOT_W-1:0]         r_cur_slot;

    // Result register
    logic                      r_out_valid;
    logic [pps_pkg::SLOT_FIELD_W-1:0] r_out_slot;
    logic                      r_out_idle;
    logic                      r_out_fin;
    logic [pps_pkg::EXEC_W-1:0] r_out_prog;
    logic [pps_pkg::TIME_FIELD_W-1:0] r_out_now;

    logic                      in_acc;
    logic                      out_acc;
    logic [EXT_W-1:0]          load_ext;
    logic                      load_in_range;
    logic                      load_wr;
    t_entry                    load_entry;
    logic                      chk_elig;
    logic                      chk_take;
    logic [pps_pkg::EXEC_W-1:0] upd_exec;
    logic                      upd_fin;
    logic                      upd_go;
    logic                      mem_wr;
    logic [SLOT_W-1:0]         mem_wr_addr;
    t_entry                    mem_wr_data;
    logic [EXT_W-1:0]          best_ext;

    assign o_stall = (r_state != ST_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;

    // Decode a load word
    assign load_ext        = EXT_W'(i_slot);
    assign load_in_range   = load_ext < EXT_W'(SLOTS);
    assign load_wr         = in_acc && (i_operation == pps_pkg::OP_LOAD) && load_in_range;
    assign load_entry.arrive = TIME_BITS'(i_arrive_at);
    assign load_entry.len    = i_run_length;
    assign load_entry.prio   = i_urgency;
    assign load_entry.exec   = '0;
    assign load_entry.done   = (i_run_length == '0);

    // Judge the slot whose data just came out of the memory
    assign chk_elig = r_chk_valid && r_rd_written && !r_rd_data.done &&
                      (r_rd_data.prio != '0) && (r_rd_data.arrive <= r_time);
    assign chk_take = chk_elig &&
                      (!r_found || (r_rd_data.prio > r_best.prio) ||
                       ((r_rd_data.prio == r_best.prio) && (r_chk_idx == r_cur_slot) &&
                        (r_cur_urg != '0)));

    // Credit the picked task
    assign upd_exec = r_best.exec + 1'b1;
    assign upd_fin  = r_found && (upd_exec == r_best.len);
    assign upd_go   = (r_state == ST_UPDATE) && (!r_out_valid || !i_stall);
    assign best_ext = EXT_W'(r_best_idx);

    // Select the single write port
    always_comb begin
        mem_wr      = load_wr || (upd_go && r_found);
        mem_wr_addr = load_wr ? load_ext[SLOT_W-1:0] : r_best_idx;
        mem_wr_data = load_entry;
        if (!load_wr) begin
            mem_wr_data      = r_best;
            mem_wr_data.exec = upd_exec;
            mem_wr_data.done = upd_fin;
        end
    end

    // Slot table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        r_rd_data <= mem[r_issue[SLOT_W-1:0]];
    end

    // Written marks: an unwritten slot reads as done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (load_wr) begin
                r_written[load_ext[SLOT_W-1:0]] <= 1'b1;
            end
            r_rd_written <= r_written[r_issue[SLOT_W-1:0]];
        end
    end

    // Sequencer: accept, scan the table, update and report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue     <= '0;
            r_chk_valid <= 1'b0;
            r_chk_idx   <= '0;
            r_found     <= 1'b0;
            r_time      <= '0;
            r_cur_urg   <= '0;
            r_cur_slot  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_issue     <= '0;
                    r_chk_valid <= 1'b0;
                    r_found     <= 1'b0;
                    if (in_acc && (i_operation == pps_pkg::OP_TICK)) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Issue the next read while judging the previous one
                    if (r_issue < CNT_W'(SLOTS)) begin
                        r_chk_valid <= 1'b1;
                        r_chk_idx   <= r_issue[SLOT_W-1:0];
                        r_issue     <= r_issue + 1'b1;
                    end else begin
                        r_chk_valid <= 1'b0;
                    end
                    if (chk_take) begin
                        r_found    <= 1'b1;
                        r_best_idx <= r_chk_idx;
                    end
                    if (r_chk_valid && (r_chk_idx == SLOT_W'(SLOTS - 1))) begin
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    // Hold until the result register is free
                    if (upd_go) begin
                        if (r_found) begin
                            r_cur_slot <= r_best_idx;
                            r_cur_urg  <= upd_fin ? '0 : r_best.prio;
                        end else begin
                            r_cur_urg  <= '0;
                        end
                        if (r_time != '1) begin
                            r_time <= r_time + 1'b1;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Best candidate payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SCAN) && chk_take) begin
            r_best <= r_rd_data;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_out_slot <= r_found ? best_ext[pps_pkg::SLOT_FIELD_W-1:0] : '0;
            r_out_idle <= !r_found;
            r_out_fin  <= upd_fin;
            r_out_prog <= r_found ? upd_exec : '0;
            r_out_now  <= (r_time != '1) ? pps_pkg::TIME_FIELD_W'(r_time + 1'b1)
                                         : pps_pkg::TIME_FIELD_W'(r_time);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_running_slot = r_out_slot;
    assign o_idle         = r_out_idle;
    assign o_finished     = r_out_fin;
    assign o_progress     = r_out_prog;
    assign o_now          = r_out_now;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the preemptive priority scheduler
// Drives load and tick words through the valid/stall input channel, takes a
// tick report from the directed table where a row gives one, else predicts
// it with a cycle-free scheduler model, and compares each report accepted on
// the output channel field by field. A directed table runs first, then
// random traffic, a run of ticks on one long task, and more random traffic.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 250_000;
    localparam int DIR_ROWS    = 24;
    localparam int RAND_WORDS  = 280;
    localparam int LONG_TICKS  = 20;

    typedef struct packed {
        logic                              op;
        logic [pps_pkg::SLOT_FIELD_W-1:0]  slot;
        logic [pps_pkg::TIME_FIELD_W-1:0]  arrive;
        logic [pps_pkg::LEN_W-1:0]         len;
        logic [pps_pkg::PRIO_W-1:0]        urg;
    } t_sched_word;

    typedef struct packed {
        logic [pps_pkg::SLOT_FIELD_W-1:0]  slot;
        logic                              idle;
        logic                              finished;
        logic [pps_pkg::EXEC_W-1:0]        progress;
        logic [pps_pkg::TIME_FIELD_W-1:0]  now;
    } t_tick_report;

    typedef struct packed {
        t_sched_word   w;
        logic          typed;
        t_tick_report  want;
    } t_dir_row;

    // Block ports
    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              i_valid      = 1'b0;
    logic                              o_stall;
    logic                              i_operation  = pps_pkg::OP_LOAD;
    logic [pps_pkg::SLOT_FIELD_W-1:0]  i_slot       = '0;
    logic [pps_pkg::TIME_FIELD_W-1:0]  i_arrive_at  = '0;
    logic [pps_pkg::LEN_W-1:0]         i_run_length = '0;
    logic [pps_pkg::PRIO_W-1:0]        i_urgency    = '0;
    logic                              o_valid;
    logic                              i_stall      = 1'b0;
    logic [pps_pkg::SLOT_FIELD_W-1:0]  o_running_slot;
    logic                              o_idle;
    logic                              o_finished;
    logic [pps_pkg::EXEC_W-1:0]        o_progress;
    logic [pps_pkg::TIME_FIELD_W-1:0]  o_now;

    // Scheduler model state
    logic [pps_pkg::TIME_FIELD_W-1:0]  tbl_arrive [pps_pkg::SLOTS_DEF];
    logic [pps_pkg::LEN_W-1:0]         tbl_len    [pps_pkg::SLOTS_DEF];
    logic [pps_pkg::PRIO_W-1:0]        tbl_prio   [pps_pkg::SLOTS_DEF];
    logic [pps_pkg::EXEC_W-1:0]        tbl_exec   [pps_pkg::SLOTS_DEF];
    bit                                tbl_done   [pps_pkg::SLOTS_DEF];
    logic [pps_pkg::TIME_FIELD_W-1:0]  sim_now;
    logic [pps_pkg::PRIO_W-1:0]        run_prio;
    logic [pps_pkg::SLOT_FIELD_W-1:0]  run_slot;

    t_tick_report  pending_ticks [$];
    t_dir_row      dir_rows [DIR_ROWS];
    int            err_count  = 0;
    int            cycles     = 0;
    int            stall_left = 0;
    bit            rx_calm    = 1'b0;

    preemptive_priority_scheduler_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_slot         (i_slot),
        .i_arrive_at    (i_arrive_at),
        .i_run_length   (i_run_length),
        .i_urgency      (i_urgency),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_running_slot (o_running_slot),
        .o_idle         (o_idle),
        .o_finished     (o_finished),
        .o_progress     (o_progress),
        .o_now          (o_now)
    );

    always #5 i_clk = ~i_clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    endtask

    function automatic bit slot_ready(input int s);
        return !tbl_done[s] && tbl_prio[s] != '0 && tbl_arrive[s] <= sim_now;
    endfunction

    // Apply one word to the model; return 1 with the report when it is a tick
    function automatic bit schedule_word(input t_sched_word w, output t_tick_report rep);
        int pick;
        bit found;
        int s;
        pick  = 0;
        found = 1'b0;
        rep   = '0;
        if (w.op == pps_pkg::OP_LOAD) begin
            tbl_arrive[w.slot] = w.arrive;
            tbl_len[w.slot]    = w.len;
            tbl_prio[w.slot]   = w.urg;
            tbl_exec[w.slot]   = '0;
            tbl_done[w.slot]   = (w.len == '0);
            return 1'b0;
        end
        // running task keeps the slot on ties
        if (run_prio != '0 && slot_ready(run_slot)) begin
            pick  = run_slot;
            found = 1'b1;
        end
        for (s = 0; s < pps_pkg::SLOTS_DEF; s++) begin
            if (slot_ready(s) && (!found || tbl_prio[s] > tbl_prio[pick])) begin
                pick  = s;
                found = 1'b1;
            end
        end
        if (found) begin
            tbl_exec[pick] = tbl_exec[pick] + 1'b1;
            rep.slot     = pps_pkg::SLOT_FIELD_W'(pick);
            rep.progress = tbl_exec[pick];
            if (tbl_exec[pick] == tbl_len[pick]) begin
                tbl_done[pick] = 1'b1;
                rep.finished   = 1'b1;
                run_prio       = '0;
            end else begin
                run_prio = tbl_prio[pick];
            end
            run_slot = pps_pkg::SLOT_FIELD_W'(pick);
        end else begin
            rep.idle = 1'b1;
            run_prio = '0;
        end
        // saturate time at all ones
        if (sim_now != '1) begin
            sim_now = sim_now + 1'b1;
        end
        rep.now = sim_now;
        return 1'b1;
    endfunction

    // Draw a word biased toward tasks that arrive soon, short bursts and close priorities
    function automatic t_sched_word rand_word();
        t_sched_word w;
        int          pick;
        w.op   = ($urandom_range(0, 9) < 6) ? pps_pkg::OP_TICK : pps_pkg::OP_LOAD;
        w.slot = pps_pkg::SLOT_FIELD_W'($urandom_range(0, pps_pkg::SLOTS_DEF - 1));
        pick = $urandom_range(0, 9);
        if (pick == 0)      w.arrive = pps_pkg::TIME_FIELD_W'($urandom);
        else if (pick == 1) w.arrive = '0;
        else                w.arrive = sim_now + pps_pkg::TIME_FIELD_W'($urandom_range(0, 6));
        pick = $urandom_range(0, 9);
        if (pick == 0)      w.len = '0;
        else if (pick == 1) w.len = pps_pkg::LEN_W'($urandom);
        else if (pick == 2) w.len = '1;
        else                w.len = pps_pkg::LEN_W'($urandom_range(1, 5));
        pick = $urandom_range(0, 9);
        if (pick == 0)      w.urg = '0;
        else if (pick == 1) w.urg = pps_pkg::PRIO_W'($urandom);
        else if (pick == 2) w.urg = '1;
        else                w.urg = pps_pkg::PRIO_W'($urandom_range(1, 3));
        return w;
    endfunction

    // Offer one word after a random gap, hold it until accepted, then predict
    task automatic send_word(input t_sched_word w, input int gap_max, input bit typed,
                             input t_tick_report want);
        int           gap;
        t_tick_report rep;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= w.op;
        i_slot       <= w.slot;
        i_arrive_at  <= w.arrive;
        i_run_length <= w.len;
        i_urgency    <= w.urg;
        do @(posedge i_clk); while (o_stall);
        if (schedule_word(w, rep)) begin
            pending_ticks.push_back(typed ? want : rep);
        end
    endtask

    // Wait on clock edges until every expected report has come
    task automatic wait_drained();
        do @(posedge i_clk); while (pending_ticks.size() != 0);
    endtask

    // Receive side: check each accepted report, then hold stall for a random count
    always @(posedge i_clk) begin
        t_tick_report exp_rep;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_ticks.size() == 0) begin
                    report_mismatch("report with nothing pending, slot", o_running_slot, 0);
                end else begin
                    exp_rep = pending_ticks.pop_front();
                    if (o_running_slot !== exp_rep.slot)
                        report_mismatch("running_slot", o_running_slot, exp_rep.slot);
                    if (o_idle !== exp_rep.idle)
                        report_mismatch("idle", o_idle, exp_rep.idle);
                    if (o_finished !== exp_rep.finished)
                        report_mismatch("finished", o_finished, exp_rep.finished);
                    if (o_progress !== exp_rep.progress)
                        report_mismatch("progress", o_progress, exp_rep.progress);
                    if (o_now !== exp_rep.now)
                        report_mismatch("now", o_now, exp_rep.now);
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, 15);
            end
            if (stall_left > 0) begin
                i_stall    <= 1'b1;
                stall_left = stall_left - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int          i;
        int          s;
        bit          calm;
        t_sched_word w;

        // Model reset: nothing runnable, time zero
        for (s = 0; s < pps_pkg::SLOTS_DEF; s++) begin
            tbl_arrive[s] = '0;
            tbl_len[s]    = '0;
            tbl_prio[s]   = '0;
            tbl_exec[s]   = '0;
            tbl_done[s]   = 1'b1;
        end
        sim_now  = '0;
        run_prio = '0;
        run_slot = '0;

        // op, slot, arrive, len, urgency | typed | slot, idle, fin, progress, now
        dir_rows = '{
            // tick right after reset reports idle
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b1,
             3'd0, 1'b1, 1'b0, 16'd0, 16'd1},
            // zero priority is never picked
            {pps_pkg::OP_LOAD, 3'd0, 16'h0000, 16'd1,    8'd0,   1'b0, 37'd0},
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b1,
             3'd0, 1'b1, 1'b0, 16'd0, 16'd2},
            // zero burst leaves the slot done
            {pps_pkg::OP_LOAD, 3'd7, 16'h0000, 16'd0,    8'd255, 1'b0, 37'd0},
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b1,
             3'd0, 1'b1, 1'b0, 16'd0, 16'd3},
            // far arrival, longest burst, top priority: not ready yet
            {pps_pkg::OP_LOAD, 3'd3, 16'hFFFF, 16'hFFFF, 8'd255, 1'b0, 37'd0},
            {pps_pkg::OP_LOAD, 3'd1, 16'h0000, 16'd2,    8'd1,   1'b0, 37'd0},
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b1,
             3'd1, 1'b0, 1'b0, 16'd1, 16'd4},
            // equal priority: running slot keeps it and finishes
            {pps_pkg::OP_LOAD, 3'd2, 16'h0000, 16'd1,    8'd1,   1'b0, 37'd0},
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b1,
             3'd1, 1'b0, 1'b1, 16'd2, 16'd5},
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b1,
             3'd2, 1'b0, 1'b1, 16'd1, 16'd6},
            // arrival equal to current time preempts
            {pps_pkg::OP_LOAD, 3'd4, 16'h0000, 16'd3,    8'd200, 1'b0, 37'd0},
            {pps_pkg::OP_LOAD, 3'd5, 16'h0006, 16'd2,    8'd201, 1'b0, 37'd0},
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b0, 37'd0},
            // reload the running slot with a lower priority
            {pps_pkg::OP_LOAD, 3'd5, 16'h0000, 16'd1,    8'd1,   1'b0, 37'd0},
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b0, 37'd0},
            {pps_pkg::OP_LOAD, 3'd6, 16'h0000, 16'hFFFF, 8'd200, 1'b0, 37'd0},
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b0, 37'd0},
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b0, 37'd0},
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b0, 37'd0},
            // reload the running slot so that it is no longer ready
            {pps_pkg::OP_LOAD, 3'd6, 16'hFFFF, 16'd5,    8'd255, 1'b0, 37'd0},
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b0, 37'd0},
            {pps_pkg::OP_TICK, 3'd0, 16'h0000, 16'd0,    8'd0,   1'b1,
             3'd0, 1'b1, 1'b0, 16'd0, 16'd13},
            {pps_pkg::OP_LOAD, 3'd0, 16'd13,   16'd1,    8'd128, 1'b0, 37'd0}
        };

        // Hold reset low, then release it
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (i = 0; i < DIR_ROWS; i++) begin
            send_word(dir_rows[i].w, 15, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random traffic, every third stretch without idling
        for (i = 0; i < RAND_WORDS; i++) begin
            calm    = ((i / 50) % 3) == 2;
            rx_calm = calm;
            send_word(rand_word(), calm ? 0 : 15, 1'b0, '0);
        end

        // Drain before the long-task run
        i_valid <= 1'b0;
        wait_drained();

        // Clear every slot, then one full-length task and one arriving far ahead
        rx_calm = 1'b1;
        for (s = 0; s < pps_pkg::SLOTS_DEF; s++) begin
            send_word({pps_pkg::OP_LOAD, pps_pkg::SLOT_FIELD_W'(s), 16'h0000, 16'd0, 8'd0},
                      0, 1'b0, '0);
        end
        send_word({pps_pkg::OP_LOAD, 3'd0, 16'h0000, 16'hFFFF, 8'd255}, 0, 1'b0, '0);
        send_word({pps_pkg::OP_LOAD, 3'd1, 16'hFFFF, 16'd3,    8'd254}, 0, 1'b0, '0);
        w = '0;
        w.op = pps_pkg::OP_TICK;
        for (i = 0; i < LONG_TICKS; i++) begin
            send_word(w, 0, 1'b0, '0);
        end

        // More random traffic
        for (i = 0; i < RAND_WORDS; i++) begin
            calm    = ((i / 50) % 3) == 1;
            rx_calm = calm;
            send_word(rand_word(), calm ? 0 : 15, 1'b0, '0);
        end
        rx_calm = 1'b0;
        i_valid <= 1'b0;

        // Wait out the last reports, then watch for strays
        wait_drained();
        repeat (pps_pkg::SLOTS_DEF + 4) @(posedge i_clk);
        if (pending_ticks.size() != 0) begin
            report_mismatch("reports still pending", pending_ticks.size(), 0);
        end
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
src/pps_pkg.sv
src/preemptive_priority_scheduler_top.sv
test/tb.sv
